[sv/bse_pkg.sv]
// Package for the Baudot shift encoder: codes, command types and the character table.
package bse_pkg;

  // Five-bit teleprinter control codes
  localparam logic [4:0] CODE_LTRS  = 5'h1F;
  localparam logic [4:0] CODE_FIGS  = 5'h1B;
  localparam logic [4:0] CODE_SPACE = 5'h04;
  localparam logic [4:0] CODE_LF    = 5'h08;
  localparam logic [4:0] CODE_NONE  = 5'h00;

  // Input bytes with a meaning of their own
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Depth of the command queue between front and back
  localparam int BSE_FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    CASE_LETTERS = 2'd0,
    CASE_FIGURES = 2'd1,
    CASE_UNKNOWN = 2'd2
  } shift_case_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_LETTER = 2'd1,
    KIND_FIGURE = 2'd2
  } char_kind_t;

  typedef struct packed {
    char_kind_t kind;
    logic [4:0] code;
  } lookup_t;

  // One queued command: one or two codes, or an error result
  typedef struct packed {
    logic       two;
    logic       bad;
    logic [4:0] code0;
    logic [4:0] code1;
  } cmd_t;

  // Letters table first, then figures; anything else has no code
  function automatic lookup_t char_lookup(input logic [7:0] ch);
    lookup_t r;
    r.kind = KIND_LETTER;
    r.code = CODE_NONE;
    case (ch)
      "A": r.code = 5'h03;  "B": r.code = 5'h19;  "C": r.code = 5'h0E;
      "D": r.code = 5'h09;  "E": r.code = 5'h01;  "F": r.code = 5'h0D;
      "G": r.code = 5'h1A;  "H": r.code = 5'h14;  "I": r.code = 5'h06;
      "J": r.code = 5'h0B;  "K": r.code = 5'h0F;  "L": r.code = 5'h12;
      "M": r.code = 5'h1C;  "N": r.code = 5'h0C;  "O": r.code = 5'h18;
      "P": r.code = 5'h16;  "Q": r.code = 5'h17;  "R": r.code = 5'h0A;
      "S": r.code = 5'h05;  "T": r.code = 5'h10;  "U": r.code = 5'h07;
      "V": r.code = 5'h1E;  "W": r.code = 5'h13;  "X": r.code = 5'h1D;
      "Y": r.code = 5'h15;  "Z": r.code = 5'h11;
      "-": begin r.kind = KIND_FIGURE; r.code = 5'h03; end
      "?": begin r.kind = KIND_FIGURE; r.code = 5'h19; end
      ":": begin r.kind = KIND_FIGURE; r.code = 5'h0E; end
      "3": begin r.kind = KIND_FIGURE; r.code = 5'h01; end
      "%": begin r.kind = KIND_FIGURE; r.code = 5'h0D; end
      "@": begin r.kind = KIND_FIGURE; r.code = 5'h1A; end
      "8": begin r.kind = KIND_FIGURE; r.code = 5'h06; end
      "(": begin r.kind = KIND_FIGURE; r.code = 5'h0F; end
      ")": begin r.kind = KIND_FIGURE; r.code = 5'h12; end
      ".": begin r.kind = KIND_FIGURE; r.code = 5'h1C; end
      ",": begin r.kind = KIND_FIGURE; r.code = 5'h0C; end
      "9": begin r.kind = KIND_FIGURE; r.code = 5'h18; end
      "0": begin r.kind = KIND_FIGURE; r.code = 5'h16; end
      "1": begin r.kind = KIND_FIGURE; r.code = 5'h17; end
      "4": begin r.kind = KIND_FIGURE; r.code = 5'h0A; end
      "'": begin r.kind = KIND_FIGURE; r.code = 5'h05; end
      "5": begin r.kind = KIND_FIGURE; r.code = 5'h10; end
      "7": begin r.kind = KIND_FIGURE; r.code = 5'h07; end
      "=": begin r.kind = KIND_FIGURE; r.code = 5'h1E; end
      "2": begin r.kind = KIND_FIGURE; r.code = 5'h13; end
      "/": begin r.kind = KIND_FIGURE; r.code = 5'h1D; end
      "6": begin r.kind = KIND_FIGURE; r.code = 5'h15; end
      "+": begin r.kind = KIND_FIGURE; r.code = 5'h11; end
      default: r.kind = KIND_NONE;
    endcase
    return r;
  endfunction

endpackage

[sv/baudot_shift_encoder.sv]
// Top level of the Baudot shift encoder: front end, command queue and back end.
//
// Input channel: write one text byte on in_text_byte with in_push; the byte
// is taken at a rising edge where in_push is high and in_full is low.
// Result channel: while out_empty is low, out_baudot_code, out_bad_char and
// out_run_end show the oldest result; pulse out_pop to take it.
// Each byte gives zero, one or two results (shift plus character, or space
// plus line feed); out_run_end marks the last result of a byte.
// A taken byte's command is queued, then loaded into the output register.
// Throughput: one result per cycle from the single output register while
// the receiver pops, so a byte with two results holds the back end for both;
// the front end takes a byte every cycle while the command queue has room.
// Reset clears the queue and output register, sets the shift case to
// unknown (the first character forces a shift code) and closes the word.
// When the receiver stalls, the result holds, the command queue fills, and
// in_full rises once it holds FIFO_DEPTH commands.
module baudot_shift_encoder import bse_pkg::*; #(
  parameter int FIFO_DEPTH = BSE_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_text_byte,
  output logic       in_full,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [4:0] out_baudot_code,
  output logic       out_bad_char,
  output logic       out_run_end
);

  cmd_t wr_cmd;
  cmd_t head_cmd;
  logic q_wr;
  logic q_rd;
  logic q_full;
  logic q_empty;

  bse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_text_byte (in_text_byte),
    .in_full      (in_full),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_cmd        (wr_cmd)
  );

  bse_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wr_cmd (wr_cmd),
    .rd     (q_rd),
    .rd_cmd (head_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  bse_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_cmd           (head_cmd),
    .q_empty         (q_empty),
    .q_rd            (q_rd),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_baudot_code (out_baudot_code),
    .out_bad_char    (out_bad_char),
    .out_run_end     (out_run_end)
  );

endmodule

[sv/bse_front.sv]
// Front end: classifies each text byte, tracks shift case and word state, queues commands.
module bse_front import bse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_text_byte,
  output logic       in_full,
  input  logic       q_full,
  output logic       q_wr,
  output cmd_t       q_cmd
);

  shift_case_t shift_case_r, shift_case_nxt;
  logic        word_open_r, word_open_nxt;
  logic        accept;
  logic        is_nl;
  logic        is_ws;
  logic [7:0]  folded;
  lookup_t     lk;
  logic        has_result;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Classify the byte and build the command
  always_comb begin
    is_nl  = (in_text_byte == CH_NL);
    is_ws  = (in_text_byte == CH_SP) || (in_text_byte == CH_TAB) ||
             (in_text_byte == CH_CR) || (in_text_byte == CH_VT) ||
             (in_text_byte == CH_FF);
    folded = ((in_text_byte >= CH_LOW_A) && (in_text_byte <= CH_LOW_Z)) ?
             (in_text_byte - CASE_OFS) : in_text_byte;
    lk     = char_lookup(folded);

    shift_case_nxt = shift_case_r;
    word_open_nxt  = word_open_r;
    has_result     = 1'b1;
    q_cmd.two      = 1'b0;
    q_cmd.bad      = 1'b0;
    q_cmd.code0    = CODE_NONE;
    q_cmd.code1    = CODE_NONE;

    if (is_nl) begin
      q_cmd.two     = word_open_r;
      q_cmd.code0   = word_open_r ? CODE_SPACE : CODE_LF;
      q_cmd.code1   = CODE_LF;
      word_open_nxt = 1'b0;
    end else if (is_ws) begin
      has_result    = word_open_r;
      q_cmd.code0   = CODE_SPACE;
      word_open_nxt = 1'b0;
    end else begin
      case (lk.kind)
        KIND_LETTER: begin
          q_cmd.two      = (shift_case_r != CASE_LETTERS);
          q_cmd.code0    = q_cmd.two ? CODE_LTRS : lk.code;
          q_cmd.code1    = lk.code;
          shift_case_nxt = CASE_LETTERS;
          word_open_nxt  = 1'b1;
        end
        KIND_FIGURE: begin
          q_cmd.two      = (shift_case_r != CASE_FIGURES);
          q_cmd.code0    = q_cmd.two ? CODE_FIGS : lk.code;
          q_cmd.code1    = lk.code;
          shift_case_nxt = CASE_FIGURES;
          word_open_nxt  = 1'b1;
        end
        default: begin
          q_cmd.bad = 1'b1;
        end
      endcase
    end
  end

  assign q_wr = accept && has_result;

  // Advance shift case and word state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_case_r <= CASE_UNKNOWN;
      word_open_r  <= 1'b0;
    end else if (accept) begin
      shift_case_r <= shift_case_nxt;
      word_open_r  <= word_open_nxt;
    end
  end

endmodule

[sv/bse_cmd_fifo.sv]
// Short command queue between the front and back ends.
module bse_cmd_fifo import bse_pkg::*; #(
  parameter int DEPTH = BSE_FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cmd_t wr_cmd,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full   = (count_r == FULL_CNT);
  assign empty  = (count_r == '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_cmd = mem_r[rd_ptr_r];

  // Wrap pointers, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    else if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_cmd;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("command queue fill level exceeds depth");

  a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (count_r == $past(count_r) + 1'b1))
    else $error("command queue write lost");

  a_read_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_rd && !do_wr) |=> (count_r == $past(count_r) - 1'b1))
    else $error("command queue read lost");

endmodule

[sv/bse_back.sv]
// Back end: expands queued commands into one or two results in the output register.
module bse_back import bse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       q_cmd,
  input  logic       q_empty,
  output logic       q_rd,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [4:0] out_baudot_code,
  output logic       out_bad_char,
  output logic       out_run_end
);

  logic       out_valid_r;
  logic [4:0] code_r, code_nxt;
  logic       bad_r, bad_nxt;
  logic       end_r, end_nxt;
  logic       sel_r, sel_nxt;
  logic       load;

  assign out_empty       = !out_valid_r;
  assign out_baudot_code = code_r;
  assign out_bad_char    = bad_r;
  assign out_run_end     = end_r;

  // Pick the next result from the head command
  always_comb begin
    load     = !q_empty && (!out_valid_r || out_pop);
    code_nxt = sel_r ? q_cmd.code1 : q_cmd.code0;
    bad_nxt  = q_cmd.bad && !sel_r;
    end_nxt  = sel_r || !q_cmd.two;
    q_rd     = load && end_nxt;
    sel_nxt  = load ? !end_nxt : sel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  // Hold payload until the result is taken
  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= code_nxt;
      bad_r  <= bad_nxt;
      end_r  <= end_nxt;
    end
  end

  a_second_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> !q_empty)
    else $error("second result pending with no command at head");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> (out_valid_r && $stable(code_r) && $stable(end_r)))
    else $error("waiting result changed under stall");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (end_r && (code_r == CODE_NONE)))
    else $error("error result is not a single zero-code result");

endmodule

[verif/tb.sv]
// Testbench for baudot_shift_encoder: random and directed text against a shift-state predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bse_pkg::*;

  typedef struct packed {
    logic [4:0] code;
    logic       bad;
    logic       last;
  } baudot_res_t;

  // Codes by alphabet position; a figure shares the code of its letter
  localparam logic [4:0] LTR_CODE [26] = '{
    5'h03, 5'h19, 5'h0E, 5'h09, 5'h01, 5'h0D, 5'h1A, 5'h14, 5'h06, 5'h0B,
    5'h0F, 5'h12, 5'h1C, 5'h0C, 5'h18, 5'h16, 5'h17, 5'h0A, 5'h05, 5'h10,
    5'h07, 5'h1E, 5'h13, 5'h1D, 5'h15, 5'h11
  };
  // Figure on each letter's position; a blank marks a position with no figure
  localparam logic [8*26-1:0] FIG_ROW = "-?: 3%@ 8 ().,9014'57=2/6+";
  localparam logic [7:0] BLANKS [5] = '{CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF};

  localparam logic [7:0] DIRECTED [25] = '{
    CH_SP, CH_NL, "a", "z", "J", "j", "0", "9", "+", 8'hFF, "-", 8'h00, CH_SP,
    CH_TAB, "Q", CH_CR, "w", CH_VT, "/", CH_FF, "8", CH_NL, CH_NL, 8'h80, 8'h7F
  };

  function automatic logic [7:0] fig_at(input int pos);
    return FIG_ROW[8*(25-pos) +: 8];
  endfunction

  // Shift-state predictor and store of codes still owed by the block
  class code_tracker;
    shift_case_t cur_case;
    bit          word_open;
    baudot_res_t pending_codes[$];
    int          mismatches;

    function new();
      cur_case   = CASE_UNKNOWN;
      word_open  = 1'b0;
      mismatches = 0;
    endfunction

    // Predict the codes of one accepted byte; return how many
    function int encode_byte(input logic [7:0] b);
      baudot_res_t res [2];
      logic [7:0]  ch;
      char_kind_t  kind;
      logic [4:0]  code;
      shift_case_t want;
      int          n;
      n    = 0;
      ch   = b;
      kind = KIND_NONE;
      code = CODE_NONE;
      if (b == CH_NL || b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_VT ||
          b == CH_FF) begin
        // close the open word, then feed the line on a newline
        if (word_open) begin
          res[n] = '{CODE_SPACE, 1'b0, 1'b0};
          n++;
        end
        if (b == CH_NL) begin
          res[n] = '{CODE_LF, 1'b0, 1'b0};
          n++;
        end
        word_open = 1'b0;
      end else begin
        if (ch >= CH_LOW_A && ch <= CH_LOW_Z) ch = ch - CASE_OFS;
        if (ch >= "A" && ch <= "Z") begin
          kind = KIND_LETTER;
          code = LTR_CODE[ch - "A"];
        end else begin
          for (int i = 0; i < 26; i++) begin
            if (fig_at(i) != CH_SP && fig_at(i) == ch) begin
              kind = KIND_FIGURE;
              code = LTR_CODE[i];
            end
          end
        end
        if (kind == KIND_NONE) begin
          // flag only; shift state and word stay as they are
          res[n] = '{CODE_NONE, 1'b1, 1'b0};
          n++;
        end else begin
          if (kind == KIND_LETTER) want = CASE_LETTERS;
          else want = CASE_FIGURES;
          if (cur_case != want) begin
            res[n] = '{(want == CASE_LETTERS) ? CODE_LTRS : CODE_FIGS, 1'b0, 1'b0};
            n++;
            cur_case = want;
          end
          res[n] = '{code, 1'b0, 1'b0};
          n++;
          word_open = 1'b1;
        end
      end
      if (n > 0) res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) pending_codes.push_back(res[i]);
      return n;
    endfunction

    // Compare one popped result with the oldest owed code
    function void check_code(input logic [4:0] code, input logic bad, input logic last);
      baudot_res_t want;
      if (pending_codes.size() == 0) begin
        $error("result with nothing owed: baudot_code %0h bad_char %0b run_end %0b",
               code, bad, last);
        mismatches++;
        return;
      end
      want = pending_codes.pop_front();
      if (code !== want.code) begin
        $error("baudot_code: expected %0h, got %0h", want.code, code);
        mismatches++;
      end
      if (bad !== want.bad) begin
        $error("bad_char: expected %0b, got %0b", want.bad, bad);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("run_end: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_full;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [4:0] out_baudot_code;
  logic       out_bad_char;
  logic       out_run_end;

  code_tracker codes;
  bit          quiet = 1'b0;
  bit          fig_mode = 1'b0;
  int          counted = 0;

  baudot_shift_encoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_text_byte    (in_text_byte),
    .in_full         (in_full),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_baudot_code (out_baudot_code),
    .out_bad_char    (out_bad_char),
    .out_run_end     (out_run_end)
  );

  initial forever #2 clk = ~clk;

  // Bound the run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Push one byte, with an occasional random gap first, and wait for its transaction
  task automatic send_byte(input logic [7:0] b, output int n);
    if (!quiet && $urandom_range(0, 99) < 9) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_text_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    n = codes.encode_byte(b);
  endtask

  // Hold the sender until every owed code has been popped
  task automatic drain();
    in_push <= 1'b0;
    do @(posedge clk); while (codes.pending_codes.size() != 0);
  endtask

  // Mostly words and numbers with runs in one case, some blanks, newlines and noise
  function automatic logic [7:0] pick_byte();
    int roll;
    int pos;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 15) fig_mode = !fig_mode;
    if (roll < 60) begin
      if (fig_mode) begin
        do pos = $urandom_range(0, 25); while (fig_at(pos) == CH_SP);
        return fig_at(pos);
      end
      pos = $urandom_range(0, 25);
      return ($urandom_range(0, 99) < 30) ? 8'("A" + pos) | CASE_OFS : 8'("A" + pos);
    end
    if (roll < 78) return BLANKS[$urandom_range(0, 4)];
    if (roll < 86) return CH_NL;
    return 8'($urandom_range(0, 255));
  endfunction

  // Random text until enough bytes have gone in
  task automatic random_text(input int upto);
    int n;
    while (counted < upto) begin
      quiet = (counted >= 700 && counted < 1000);
      send_byte(pick_byte(), n);
      counted++;
    end
  endtask

  // Pop results with random stalls and check each transaction
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) codes.check_code(out_baudot_code, out_bad_char, out_run_end);
      out_pop <= quiet || $urandom_range(0, 99) >= 9;
    end
  end

  initial begin
    int n;
    codes = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIRECTED[i]) send_byte(DIRECTED[i], n);
    drain();
    random_text(1200);
    drain();
    random_text(1700);
    drain();
    repeat (20) @(posedge clk);
    if (codes.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
